// ----- src/tcf_pkg.sv -----
// Shared types and constants for the timestamp formatter.
`timescale 1ns / 1ps

package tcf_pkg;

   localparam int COUNT_W    = 64;
   localparam int FREQ_W     = 32;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 1;
   localparam int CHAR_W     = 8;
   localparam int STEP_W     = 7;
   localparam int USEC_W     = 20;
   localparam int PROD_W     = FREQ_W + USEC_W;
   localparam int USEC_DIGITS = 6;
   localparam int USEC_BCD_W  = USEC_DIGITS * 4;

   localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;

   // divider passes: full count, then remainder * 1e6 (52 significant bits)
   localparam logic [STEP_W-1:0] SEC_STEPS  = 7'd64;
   localparam logic [STEP_W-1:0] USEC_STEPS = 7'd52;
   localparam logic [STEP_W-1:0] USEC_LAST  = 7'd5;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_OPEN  = 8'h5B;
   localparam logic [CHAR_W-1:0] CHAR_CLOSE = 8'h5D;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TICK_FREQUENCY = 1'b0,
      CSR_COUNT_OFFSET   = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEC_DIV,
      ST_USEC_MUL,
      ST_USEC_DIV,
      ST_OPEN,
      ST_SEC_TEXT,
      ST_DOT,
      ST_USEC_TEXT,
      ST_CLOSE,
      ST_TAIL
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } div_ctrl_type;

   // double-dabble correction of one BCD digit
   function automatic logic [3:0] bcd_adjust(input logic [3:0] digit);
      bcd_adjust = (digit >= 4'd5) ? digit + 4'd3 : digit;
   endfunction

endpackage

// ----- src/tcf_req_if.sv -----
// Request channel: one raw timer count per request.
`timescale 1ns / 1ps

interface tcf_req_if;
   logic                         valid;
   logic                         ready;
   logic [tcf_pkg::COUNT_W-1:0]  timer_count;

   modport source (output valid, output timer_count, input ready);
   modport sink   (input valid, input timer_count, output ready);
endinterface

// ----- src/tcf_rsp_if.sv -----
// Response channel: one timestamp character per transfer.
`timescale 1ns / 1ps

interface tcf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tcf_pkg::CHAR_W-1:0]   text_char;
   logic                         last_char;

   modport source (output valid, output text_char, output last_char, input ready);
   modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

// ----- src/tcf_serial_div.sv -----
// Bit-serial restoring divider: one quotient bit per step, MSB first.
`timescale 1ns / 1ps

module tcf_serial_div (
   input  logic                          clock,
   input  tcf_pkg::div_ctrl_type         ctrl,
   input  logic [tcf_pkg::COUNT_W-1:0]   load_value,
   input  logic [tcf_pkg::FREQ_W-1:0]    divisor,
   output logic                          q_bit,
   output logic [tcf_pkg::FREQ_W-1:0]    remainder
);

   logic [tcf_pkg::COUNT_W-1:0] dividend_ff, dividend_in;
   logic [tcf_pkg::FREQ_W-1:0]  rem_ff, rem_in;
   logic [tcf_pkg::FREQ_W:0]    trial;
   logic [tcf_pkg::FREQ_W:0]    diff;
   logic                        ge;

   assign trial = {rem_ff, dividend_ff[tcf_pkg::COUNT_W-1]};
   assign ge    = trial >= {1'b0, divisor};
   assign diff  = trial - {1'b0, divisor};
   // a zero divisor yields all-zero quotient bits
   assign q_bit     = ge && (divisor != '0);
   assign remainder = rem_ff;

   always_comb begin
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      if (ctrl.load) begin
         dividend_in = load_value;
         rem_in      = '0;
      end else if (ctrl.step) begin
         dividend_in = {dividend_ff[tcf_pkg::COUNT_W-2:0], 1'b0};
         rem_in      = ge ? diff[tcf_pkg::FREQ_W-1:0] : trial[tcf_pkg::FREQ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
   end

endmodule

// ----- src/timer_count_timestamp_formatter.sv -----
// Top level: timer count to "[sssss.uuuuuu] " text, one character per response.
//
//   channel  dir  handshake        payload
//   req      in   valid/ready      timer_count[63:0]
//   rsp      out  valid/ready      text_char[7:0], last_char
//   csr      in   csr_wr_en        csr_index[0:0], csr_wdata[63:0]
//
// For each request the shared bit-serial divider runs one pass over the 64-bit
// count and one over the 52-bit microsecond product, while BCD digits build up
// alongside it. Characters then leave one per cycle through an output register
// while rsp is not stalled and no leading zero is being skipped.
// A new request is taken while the last character still waits in that register.
// Synchronous reset clears the control state and both configuration registers.
`timescale 1ns / 1ps

module timer_count_timestamp_formatter #(
   parameter int SECONDS_DIGITS    = 15,
   parameter int MIN_SECONDS_WIDTH = 5
) (
   input  logic                             clock,
   input  logic                             reset,
   tcf_req_if.sink                          req,
   tcf_rsp_if.source                        rsp,
   input  logic                             csr_wr_en,
   input  logic [tcf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tcf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int SEC_BCD_W = SECONDS_DIGITS * 4;
   localparam int SEC_W     = (SECONDS_DIGITS > MIN_SECONDS_WIDTH) ?
                              SECONDS_DIGITS : MIN_SECONDS_WIDTH;
   localparam int K_W       = $clog2(SEC_W);

   localparam logic [K_W-1:0] K_START = K_W'(SEC_W - 1);
   localparam logic [K_W:0]   K_SD    = (K_W+1)'(SECONDS_DIGITS);
   localparam logic [K_W:0]   K_MSW   = (K_W+1)'(MIN_SECONDS_WIDTH);

   tcf_pkg::state_type state_ff, state_in;

   logic [tcf_pkg::FREQ_W-1:0]   freq_ff, freq_in;
   logic [tcf_pkg::COUNT_W-1:0]  offset_ff, offset_in;

   logic [tcf_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [K_W-1:0]               sec_k_ff, sec_k_in;
   logic                         nz_seen_ff, nz_seen_in;
   logic                         sec_hi_ff, sec_hi_in;
   logic [SEC_BCD_W-1:0]         sec_bcd_ff, sec_bcd_in;
   logic [tcf_pkg::USEC_BCD_W-1:0] usec_bcd_ff, usec_bcd_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [tcf_pkg::CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic                         rsp_last_ff, rsp_last_in;

   tcf_pkg::div_ctrl_type        div_ctrl;
   logic [tcf_pkg::COUNT_W-1:0]  div_load;
   logic                         q_bit;
   logic [tcf_pkg::FREQ_W-1:0]   div_rem;
   logic [tcf_pkg::PROD_W-1:0]   usec_prod;

   logic [SEC_BCD_W-1:0]         sec_adj;
   logic [tcf_pkg::USEC_BCD_W-1:0] usec_adj;
   logic [3:0]                   sec_top;
   logic [3:0]                   usec_top;
   logic                         out_free;
   logic                         emit;
   logic [tcf_pkg::CHAR_W-1:0]   emit_char;
   logic                         emit_last;
   logic                         in_pad;
   logic                         started;

   tcf_serial_div u_div (
      .clock      (clock),
      .ctrl       (div_ctrl),
      .load_value (div_load),
      .divisor    (freq_ff),
      .q_bit      (q_bit),
      .remainder  (div_rem)
   );

   assign usec_prod = div_rem * tcf_pkg::USEC_PER_SEC;
   assign sec_top   = sec_bcd_ff[SEC_BCD_W-1 -: 4];
   assign usec_top  = usec_bcd_ff[tcf_pkg::USEC_BCD_W-1 -: 4];
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign in_pad    = {1'b0, sec_k_ff} >= K_SD;
   assign started   = sec_hi_ff || nz_seen_ff || (sec_top != 4'd0) || (sec_k_ff == '0);

   assign req.ready     = (state_ff == tcf_pkg::ST_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.text_char = rsp_char_ff;
   assign rsp.last_char = rsp_last_ff;

   always_comb begin
      for (int i = 0; i < SECONDS_DIGITS; i++) begin
         sec_adj[i*4 +: 4] = tcf_pkg::bcd_adjust(sec_bcd_ff[i*4 +: 4]);
      end
      for (int i = 0; i < tcf_pkg::USEC_DIGITS; i++) begin
         usec_adj[i*4 +: 4] = tcf_pkg::bcd_adjust(usec_bcd_ff[i*4 +: 4]);
      end
   end

   // configuration writes
   always_comb begin
      freq_in   = freq_ff;
      offset_in = offset_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            tcf_pkg::CSR_TICK_FREQUENCY: freq_in   = csr_wdata[tcf_pkg::FREQ_W-1:0];
            tcf_pkg::CSR_COUNT_OFFSET:   offset_in = csr_wdata;
            default:                     ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      sec_k_in     = sec_k_ff;
      nz_seen_in   = nz_seen_ff;
      sec_hi_in    = sec_hi_ff;
      sec_bcd_in   = sec_bcd_ff;
      usec_bcd_in  = usec_bcd_ff;
      div_ctrl     = '0;
      div_load     = req.timer_count + offset_ff;
      emit         = 1'b0;
      emit_char    = tcf_pkg::CHAR_SPACE;
      emit_last    = 1'b0;

      unique case (state_ff)
         tcf_pkg::ST_IDLE: begin
            if (req.valid) begin
               div_ctrl.load = 1'b1;
               step_in       = '0;
               nz_seen_in    = 1'b0;
               sec_hi_in     = 1'b0;
               sec_bcd_in    = '0;
               usec_bcd_in   = '0;
               state_in      = tcf_pkg::ST_SEC_DIV;
            end
         end
         tcf_pkg::ST_SEC_DIV: begin
            div_ctrl.step = 1'b1;
            // digits above the kept ones only matter as nonzero or not
            sec_hi_in  = sec_hi_ff | sec_adj[SEC_BCD_W-1];
            sec_bcd_in = {sec_adj[SEC_BCD_W-2:0], q_bit};
            step_in    = step_ff + 1'b1;
            if (step_ff == tcf_pkg::SEC_STEPS - 1'b1) begin
               state_in = tcf_pkg::ST_USEC_MUL;
            end
         end
         tcf_pkg::ST_USEC_MUL: begin
            div_ctrl.load = 1'b1;
            div_load = {usec_prod, (tcf_pkg::COUNT_W - tcf_pkg::PROD_W)'(0)};
            step_in  = '0;
            state_in = tcf_pkg::ST_USEC_DIV;
         end
         tcf_pkg::ST_USEC_DIV: begin
            div_ctrl.step = 1'b1;
            usec_bcd_in = {usec_adj[tcf_pkg::USEC_BCD_W-2:0], q_bit};
            step_in     = step_ff + 1'b1;
            if (step_ff == tcf_pkg::USEC_STEPS - 1'b1) begin
               state_in = tcf_pkg::ST_OPEN;
            end
         end
         tcf_pkg::ST_OPEN: begin
            emit_char = tcf_pkg::CHAR_OPEN;
            if (out_free) begin
               emit     = 1'b1;
               sec_k_in = K_START;
               state_in = tcf_pkg::ST_SEC_TEXT;
            end
         end
         tcf_pkg::ST_SEC_TEXT: begin
            if (in_pad) begin
               if (out_free) begin
                  emit     = 1'b1;
                  sec_k_in = sec_k_ff - 1'b1;
               end
            end else if (started) begin
               emit_char = tcf_pkg::CHAR_ZERO + {4'd0, sec_top};
               if (out_free) begin
                  emit       = 1'b1;
                  nz_seen_in = 1'b1;
                  sec_bcd_in = {sec_bcd_ff[SEC_BCD_W-5:0], 4'd0};
                  sec_k_in   = sec_k_ff - 1'b1;
                  if (sec_k_ff == '0) begin
                     state_in = tcf_pkg::ST_DOT;
                  end
               end
            end else if ({1'b0, sec_k_ff} < K_MSW) begin
               if (out_free) begin
                  emit       = 1'b1;
                  sec_bcd_in = {sec_bcd_ff[SEC_BCD_W-5:0], 4'd0};
                  sec_k_in   = sec_k_ff - 1'b1;
               end
            end else begin
               // leading zero beyond the minimum width: no character
               sec_bcd_in = {sec_bcd_ff[SEC_BCD_W-5:0], 4'd0};
               sec_k_in   = sec_k_ff - 1'b1;
            end
         end
         tcf_pkg::ST_DOT: begin
            emit_char = tcf_pkg::CHAR_DOT;
            if (out_free) begin
               emit     = 1'b1;
               step_in  = '0;
               state_in = tcf_pkg::ST_USEC_TEXT;
            end
         end
         tcf_pkg::ST_USEC_TEXT: begin
            emit_char = tcf_pkg::CHAR_ZERO + {4'd0, usec_top};
            if (out_free) begin
               emit        = 1'b1;
               usec_bcd_in = {usec_bcd_ff[tcf_pkg::USEC_BCD_W-5:0], 4'd0};
               step_in     = step_ff + 1'b1;
               if (step_ff == tcf_pkg::USEC_LAST) begin
                  state_in = tcf_pkg::ST_CLOSE;
               end
            end
         end
         tcf_pkg::ST_CLOSE: begin
            emit_char = tcf_pkg::CHAR_CLOSE;
            if (out_free) begin
               emit     = 1'b1;
               state_in = tcf_pkg::ST_TAIL;
            end
         end
         tcf_pkg::ST_TAIL: begin
            emit_last = 1'b1;
            if (out_free) begin
               emit     = 1'b1;
               state_in = tcf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcf_pkg::ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_char;
         rsp_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         freq_ff      <= '0;
         offset_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         freq_ff      <= freq_in;
         offset_ff    <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      sec_k_ff    <= sec_k_in;
      nz_seen_ff  <= nz_seen_in;
      sec_hi_ff   <= sec_hi_in;
      sec_bcd_ff  <= sec_bcd_in;
      usec_bcd_ff <= usec_bcd_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule
